// File: sv/dcfir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir_pkg
// Shared constants and controller/datapath types for the direct-form FIR.
// ----------------------------------------------------------------------------
package dcfir_pkg;

    localparam int MAX_TAPS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int                     TAP_COUNT_W   = 7;
    localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RST = 7'd1;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    typedef struct packed {
        logic load_tap;
        logic push_sample;
        logic push_zero;
        logic clear_run;
        logic issue;
        logic issue_first;
        logic issue_last;
        logic store_out;
        logic out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic acc_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: sv/dcfir_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir_in_if / dcfir_out_if
// Valid/ready channels for input items and convolution results.
// ----------------------------------------------------------------------------
interface dcfir_in_if #(
    parameter int IDX_W       = 6,
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [IDX_W-1:0]              tap_index;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;

    modport source (output valid, func, tap_index, sample, is_last, input ready);
    modport sink   (input valid, func, tap_index, sample, is_last, output ready);
endinterface

interface dcfir_out_if #(
    parameter int Y_BITS = 38
);
    logic                     valid;
    logic                     ready;
    logic signed [Y_BITS-1:0] y_value;
    logic                     last_of_run;

    modport source (output valid, y_value, last_of_run, input ready);
    modport sink   (input valid, y_value, last_of_run, output ready);
endinterface

// File: sv/dcfir_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir_ctrl
// Sequencer: takes items, holds tap_count, steps the MAC over the taps and
// walks the zero-padded tail of a run.
// ----------------------------------------------------------------------------
module dcfir_ctrl #(
    parameter int MAX_TAPS = dcfir_pkg::MAX_TAPS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [dcfir_pkg::TAP_COUNT_W-1:0] i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic                             i_is_last,
    input  dcfir_pkg::t_dp_sts               i_sts,
    output dcfir_pkg::t_dp_cmd               o_cmd,
    output logic [dcfir_pkg::idx_width(MAX_TAPS)-1:0] o_tap_idx
);

    localparam int IDX_W = dcfir_pkg::idx_width(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_STORE = 2'd3;

    logic [1:0]                        r_state, n_state;
    logic [dcfir_pkg::TAP_COUNT_W-1:0] r_tap_count;
    logic [CNT_W-1:0]                  r_m, n_m;
    logic [CNT_W-1:0]                  r_tail, n_tail;
    logic                              r_last_run, n_last_run;
    logic [IDX_W-1:0]                  r_tap_cnt, n_tap_cnt;
    logic [CNT_W-1:0]                  w_m_eff;
    logic                              w_accept;
    logic                              w_issue_last;

    always_comb begin
        if (r_tap_count == '0) begin
            w_m_eff = CNT_W'(1);
        end else if (32'(r_tap_count) > MAX_TAPS) begin
            w_m_eff = CNT_W'(MAX_TAPS);
        end else begin
            w_m_eff = CNT_W'(r_tap_count);
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_issue_last = (CNT_W'(r_tap_cnt) == (r_m - CNT_W'(1)));
    assign o_tap_idx    = r_tap_cnt;

    always_comb begin
        n_state    = r_state;
        n_m        = r_m;
        n_tail     = r_tail;
        n_last_run = r_last_run;
        n_tap_cnt  = r_tap_cnt;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_func == dcfir_pkg::FUNC_LOAD) begin
                        o_cmd.load_tap = 1'b1;
                    end else begin
                        o_cmd.push_sample = 1'b1;
                        n_m        = w_m_eff;
                        n_tail     = i_is_last ? (w_m_eff - CNT_W'(1)) : '0;
                        n_last_run = i_is_last;
                        n_tap_cnt  = '0;
                        n_state    = S_MAC;
                    end
                end
            end
            S_MAC: begin
                o_cmd.issue       = 1'b1;
                o_cmd.issue_first = (r_tap_cnt == '0);
                o_cmd.issue_last  = w_issue_last;
                n_tap_cnt         = r_tap_cnt + IDX_W'(1);
                if (w_issue_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_sts.acc_done) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                if (i_sts.out_free) begin
                    o_cmd.store_out = 1'b1;
                    o_cmd.out_last  = r_last_run && (r_tail == '0);
                    if (r_tail != '0) begin
                        o_cmd.push_zero = 1'b1;
                        n_tail    = r_tail - CNT_W'(1);
                        n_tap_cnt = '0;
                        n_state   = S_MAC;
                    end else begin
                        o_cmd.clear_run = r_last_run;
                        n_state         = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tap_count <= dcfir_pkg::TAP_COUNT_RST;
            r_m         <= CNT_W'(1);
            r_tail      <= '0;
            r_last_run  <= 1'b0;
            r_tap_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_m        <= n_m;
            r_tail     <= n_tail;
            r_last_run <= n_last_run;
            r_tap_cnt  <= n_tap_cnt;
            if (i_cfg_we) begin
                r_tap_count <= i_cfg_wdata;
            end
        end
    end

`ifndef SYNTH
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.acc_done |-> (r_state == S_WAIT))
        else $error("accumulator finished outside the wait state");

    a_tap_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC) |-> (CNT_W'(r_tap_cnt) < r_m))
        else $error("tap counter ran past tap count");

    a_tail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_tail < r_m))
        else $error("tail count exceeds tap count");
`endif

endmodule

// File: sv/dcfir_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfir_dp
// Tap and history memories, fill tracking, pipelined MAC and result register.
// ----------------------------------------------------------------------------
module dcfir_dp #(
    parameter int MAX_TAPS    = dcfir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  dcfir_pkg::t_dp_cmd                        i_cmd,
    output dcfir_pkg::t_dp_sts                        o_sts,
    input  logic [dcfir_pkg::idx_width(MAX_TAPS)-1:0] i_tap_idx,
    input  logic [dcfir_pkg::idx_width(MAX_TAPS)-1:0] i_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]             i_sample,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic signed [2*SAMPLE_BITS+dcfir_pkg::idx_width(MAX_TAPS)-1:0] o_y_value,
    output logic                                      o_last_of_run
);

    localparam int IDX_W  = dcfir_pkg::idx_width(MAX_TAPS);
    localparam int FILL_W = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int Y_BITS = PROD_W + IDX_W;

    logic signed [SAMPLE_BITS-1:0] r_tap_mem  [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] r_hist_mem [MAX_TAPS];

    logic [IDX_W-1:0]  r_head, n_head;
    logic [FILL_W-1:0] r_fill;
    logic [IDX_W-1:0]  w_hist_addr;
    logic              w_push;

    logic signed [SAMPLE_BITS-1:0] r_tap_q, r_hist_q, w_hist_op;
    logic                          r_s1_valid, r_s1_first, r_s1_last, r_s1_live;
    logic signed [PROD_W-1:0]      r_prod;
    logic                          r_s2_valid, r_s2_first, r_s2_last;
    logic signed [Y_BITS-1:0]      r_acc;
    logic                          r_acc_done;
    logic                          r_out_valid;
    logic signed [Y_BITS-1:0]      r_out_y;
    logic                          r_out_last;

    assign w_push = i_cmd.push_sample || i_cmd.push_zero;
    assign n_head = (r_head == IDX_W'(MAX_TAPS - 1)) ? '0 : (r_head + IDX_W'(1));
    assign w_hist_addr = (i_tap_idx > r_head) ? (r_head + IDX_W'(MAX_TAPS) - i_tap_idx)
                                              : (r_head - i_tap_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_tap && (32'(i_tap_index) < MAX_TAPS)) begin
            r_tap_mem[i_tap_index] <= i_sample;
        end
        if (w_push) begin
            r_hist_mem[n_head] <= i_cmd.push_sample ? i_sample : '0;
        end
        r_tap_q  <= r_tap_mem[i_tap_idx];
        r_hist_q <= r_hist_mem[w_hist_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.clear_run) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (w_push) begin
            r_head <= n_head;
            if (r_fill != FILL_W'(MAX_TAPS)) begin
                r_fill <= r_fill + FILL_W'(1);
            end
        end
    end

    // entries older than the fill count read as zero
    assign w_hist_op = r_s1_live ? r_hist_q : '0;

    always_ff @(posedge i_clk) begin
        r_s1_first <= i_cmd.issue_first;
        r_s1_last  <= i_cmd.issue_last;
        r_s1_live  <= (FILL_W'(i_tap_idx) < r_fill);
        r_prod     <= r_tap_q * w_hist_op;
        r_s2_first <= r_s1_first;
        r_s2_last  <= r_s1_last;
        if (r_s2_valid) begin
            r_acc <= r_s2_first ? Y_BITS'(r_prod) : (r_acc + Y_BITS'(r_prod));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_acc_done <= 1'b0;
        end else begin
            r_s1_valid <= i_cmd.issue;
            r_s2_valid <= r_s1_valid;
            r_acc_done <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_out) begin
            r_out_y    <= r_acc;
            r_out_last <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.store_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.acc_done = r_acc_done;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_y_value      = r_out_y;
    assign o_last_of_run  = r_out_last;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fill) <= MAX_TAPS)
        else $error("history fill count above depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.store_out |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten before transfer");

    a_no_push_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid || r_s2_valid) |-> !w_push)
        else $error("history pushed while MAC in flight");
`endif

endmodule

// File: sv/direct_convolution_fir_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_convolution_fir_unit
// Direct-form FIR computing the full linear convolution with loaded taps.
// ----------------------------------------------------------------------------
// Usage:
//   i_in  : valid/ready input channel. func = load writes sample into tap
//           tap_index (no result); func = sample pushes a sample
//           and produces one y_value. is_last adds the M-1 tail outputs.
//   o_out : valid/ready result channel, y_value plus last_of_run on the
//           final output of a run, after which the history is cleared.
//   i_cfg_we / i_cfg_wdata : tap_count (M), written by the user only while idle; not enforced.
// Timing: one multiply-accumulate per tap through a single MAC pipeline
//   (memory read, multiply, accumulate). A sample item holds the block from
//   transfer until its result is stored, as does each tail output.
//   Input is taken again once the result is in the output register.
// Reset: tap_count = 1, history empty; tap store is undefined until loaded.
// Stall: a held output register stops the block before it stores the next
//   result; input is not taken until that store completes.
// ----------------------------------------------------------------------------
module direct_convolution_fir_unit #(
    parameter int MAX_TAPS    = dcfir_pkg::MAX_TAPS_DEF,
    parameter int SAMPLE_BITS = dcfir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcfir_pkg::TAP_COUNT_W-1:0] i_cfg_wdata,
    dcfir_in_if.sink                          i_in,
    dcfir_out_if.source                       o_out
);

    localparam int IDX_W = dcfir_pkg::idx_width(MAX_TAPS);

    dcfir_pkg::t_dp_cmd w_cmd;
    dcfir_pkg::t_dp_sts w_sts;
    logic [IDX_W-1:0]   w_tap_idx;

    dcfir_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_func      (i_in.func),
        .i_is_last   (i_in.is_last),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_tap_idx   (w_tap_idx)
    );

    dcfir_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_tap_idx     (w_tap_idx),
        .i_tap_index   (i_in.tap_index),
        .i_sample      (i_in.sample),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_y_value     (o_out.y_value),
        .o_last_of_run (o_out.last_of_run)
    );

endmodule
